### hw/rtl/slid_pkg.sv
// Shared constants and types for the sorted list engine.
package slid_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 6;
	localparam int ST_W      = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                    cmp;
		logic                    ins;
		logic                    del;
		logic signed [VAL_W-1:0] cmp_val;
		logic signed [VAL_W-1:0] ins_val;
		logic [IDX_W-1:0]        idx;
	} slid_ctrl_t;

	// per-cell compare results handed to neighbor and controller
	typedef struct packed {
		logic le;
		logic eq;
	} slid_flags_t;

endpackage

### hw/rtl/slid_in_if.sv
// Command channel: operation kind, value and index.
interface slid_in_if;
	logic                                valid;
	logic                                ready;
	logic [slid_pkg::KIND_W-1:0]         kind;
	logic signed [slid_pkg::VAL_W-1:0]   value;
	logic [slid_pkg::IDX_W-1:0]          index;

	modport source (output valid, output kind, output value, output index, input ready);
	modport sink (input valid, input kind, input value, input index, output ready);
endinterface

### hw/rtl/slid_out_if.sv
// Response channel: status, entry count and read data.
interface slid_out_if #(
	parameter int CNT_W = 7
);
	logic                                valid;
	logic                                ready;
	logic [slid_pkg::ST_W-1:0]           status;
	logic [CNT_W-1:0]                    count;
	logic signed [slid_pkg::VAL_W-1:0]   read_value;

	modport source (output valid, output status, output count, output read_value, input ready);
	modport sink (input valid, input status, input count, input read_value, output ready);
endinterface

### hw/rtl/slid_cell.sv
// One list position: holds an entry, compares it, shifts from a neighbor.
module slid_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  slid_pkg::slid_ctrl_t                ctrl,
	input  logic [CNT_W-1:0]                    count,
	input  logic                                left_le,
	input  logic signed [slid_pkg::VAL_W-1:0]   left_entry,
	input  logic signed [slid_pkg::VAL_W-1:0]   right_entry,
	output logic signed [slid_pkg::VAL_W-1:0]   entry,
	output slid_pkg::slid_flags_t               flags,
	output logic signed [slid_pkg::VAL_W-1:0]   rd
);

	localparam bit REACH = INDEX < (1 << slid_pkg::IDX_W);
	localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);
	localparam logic [slid_pkg::IDX_W-1:0] POS_IDX = slid_pkg::IDX_W'(INDEX);

	logic signed [slid_pkg::VAL_W-1:0] entry_q;
	logic                              le_q;
	logic                              ge_q;
	logic                              hit_q;
	logic                              valid;

	assign valid = POS < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q  <= 1'b0;
			ge_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (ctrl.cmp) begin
			le_q  <= valid && (entry_q <= ctrl.cmp_val);
			ge_q  <= valid && (entry_q >= ctrl.cmp_val);
			hit_q <= REACH && (ctrl.idx == POS_IDX);
		end
	end

	// insert: positions past the insertion point move up by one
	// delete: positions from the first match move down by one
	always_ff @(posedge clk) begin
		if (ctrl.ins && !le_q) begin
			entry_q <= left_le ? ctrl.ins_val : left_entry;
		end else if (ctrl.del && ge_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry    = entry_q;
	assign flags.le = le_q;
	assign flags.eq = le_q && ge_q;
	assign rd       = hit_q ? entry_q : '0;

endmodule

### hw/rtl/sorted_list_insert_delete.sv
// Sorted list engine top level: controller and row of list cells.
// A command is captured on acceptance while the cells compare it; the result is
// then registered in the execute state, later only while an earlier response is
// still waiting. A new command is taken only in the idle state, after the compare
// pass and the update pass through the cell row.
// Reset clears the entry count, the control state and the response valid;
// list entries are not cleared.
module sorted_list_insert_delete #(
	parameter int DEPTH = slid_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slid_in_if.sink    cmd,
	slid_out_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > slid_pkg::IDX_W) ? CNT_W : slid_pkg::IDX_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                                state_q;
	logic [slid_pkg::KIND_W-1:0]         kind_q;
	logic signed [slid_pkg::VAL_W-1:0]   value_q;
	logic [slid_pkg::IDX_W-1:0]          index_q;
	logic [CNT_W-1:0]                    count_q;

	logic                                out_valid_q;
	logic [slid_pkg::ST_W-1:0]           status_q;
	logic [CNT_W-1:0]                    out_count_q;
	logic signed [slid_pkg::VAL_W-1:0]   read_value_q;

	logic                                cmd_acc;
	logic                                exec;
	logic                                full;
	logic                                found;
	logic                                in_range;
	slid_pkg::slid_ctrl_t                ctrl;

	logic signed [slid_pkg::VAL_W-1:0]   entry_w [DEPTH];
	logic signed [slid_pkg::VAL_W-1:0]   rd_w [DEPTH];
	slid_pkg::slid_flags_t               flags_w [DEPTH];
	logic [DEPTH-1:0]                    eq_vec;
	logic signed [slid_pkg::VAL_W-1:0]   rd_or;

	logic [CNT_W-1:0]                    count_nxt;
	logic [slid_pkg::ST_W-1:0]           status_nxt;
	logic signed [slid_pkg::VAL_W-1:0]   read_nxt;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign exec      = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	assign full     = (count_q == FULL_CNT);
	assign found    = |eq_vec;
	assign in_range = CMP_W'(index_q) < CMP_W'(count_q);

	assign ctrl.cmp     = cmd_acc;
	assign ctrl.ins     = exec && (kind_q == slid_pkg::KIND_INSERT) && !full;
	assign ctrl.del     = exec && (kind_q == slid_pkg::KIND_DELETE) && found;
	assign ctrl.cmp_val = cmd.value;
	assign ctrl.ins_val = value_q;
	assign ctrl.idx     = cmd.index;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                              left_le;
		logic signed [slid_pkg::VAL_W-1:0] left_entry;
		logic signed [slid_pkg::VAL_W-1:0] right_entry;

		if (i == 0) begin : g_first
			assign left_le    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_le    = flags_w[i-1].le;
			assign left_entry = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		slid_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_le     (left_le),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.flags       (flags_w[i]),
			.rd          (rd_w[i])
		);

		assign eq_vec[i] = flags_w[i].eq;
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd_w[i];
		end
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = slid_pkg::ST_OK;
		read_nxt   = '0;
		unique case (kind_q)
			slid_pkg::KIND_INSERT: begin
				if (full) begin
					status_nxt = slid_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			slid_pkg::KIND_DELETE: begin
				if (found) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = slid_pkg::ST_NOT_FOUND;
				end
			end
			slid_pkg::KIND_READ: begin
				if (in_range) begin
					read_nxt = rd_or;
				end else begin
					status_nxt = slid_pkg::ST_RANGE;
				end
			end
			default: begin
				count_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				state_q <= S_EXEC;
			end else if (exec) begin
				state_q <= S_IDLE;
			end
			if (exec) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			kind_q  <= cmd.kind;
			value_q <= cmd.value;
			index_q <= cmd.index;
		end
		if (exec) begin
			status_q     <= status_nxt;
			out_count_q  <= count_nxt;
			read_value_q <= read_nxt;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = out_count_q;
	assign rsp.read_value = read_value_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (kind_q == slid_pkg::KIND_INSERT) && !full |=>
		count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the count");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (kind_q == slid_pkg::KIND_DELETE) && found |=>
		count_q == $past(count_q) - 1'b1)
		else $error("delete did not shrink the count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (kind_q == slid_pkg::KIND_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(found ? eq_vec & ~(eq_vec << 1) : eq_vec))
		else $error("match flags not contiguous");
`endif

endmodule

### test/sorted_list_insert_delete_test.sv
// Testbench for the sorted list engine: directed and random command beats checked against a local list model.
`timescale 1ns / 100ps

module sorted_list_insert_delete_test;

	localparam int LIST_DEPTH  = slid_pkg::DEPTH_DEF;
	localparam int RAND_CMDS   = 1850;
	localparam int TAIL_CMDS   = 150;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [slid_pkg::KIND_W-1:0]        kind;
		logic signed [slid_pkg::VAL_W-1:0]  value;
		logic [slid_pkg::IDX_W-1:0]         index;
		bit                                 hold;
	} list_cmd_t;

	typedef struct {
		logic [slid_pkg::ST_W-1:0]          status;
		logic [6:0]                         count;
		logic signed [slid_pkg::VAL_W-1:0]  read_value;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	slid_in_if cmd_if();
	slid_out_if #(.CNT_W(7)) rsp_if();

	sorted_list_insert_delete #(.DEPTH(LIST_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	list_cmd_t                         pending_cmds[$];
	list_rsp_t                         expected_rsp[$];
	logic signed [slid_pkg::VAL_W-1:0] gen_held[$];

	logic signed [slid_pkg::VAL_W-1:0] list_vals[LIST_DEPTH];
	int                                list_len = 0;

	int        cmd_beats;
	int        rsp_beats;
	int        idle_cycles;
	int        fail_count = 0;
	int        kind_seen[4] = '{0, 0, 0, 0};
	int        status_seen[4] = '{0, 0, 0, 0};
	bit        quiet_tail;
	int        send_gap;
	int        send_mode_cnt;
	bit        send_gappy;
	int        rcv_stall;
	int        rcv_mode_cnt;
	bit        rcv_gappy;
	list_cmd_t head_cmd;

	function automatic list_rsp_t list_step(input list_cmd_t c);
		list_rsp_t r;
		int        pos;
		int        hit;
		r.status     = slid_pkg::ST_OK;
		r.read_value = '0;
		case (c.kind)
			slid_pkg::KIND_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = slid_pkg::ST_FULL;
				end else begin
					pos = list_len;
					while (pos > 0 && list_vals[pos-1] > c.value) begin
						list_vals[pos] = list_vals[pos-1];
						pos--;
					end
					list_vals[pos] = c.value;
					list_len++;
				end
			end
			slid_pkg::KIND_DELETE: begin
				hit = -1;
				for (pos = 0; pos < list_len; pos++)
					if (hit < 0 && list_vals[pos] == c.value)
						hit = pos;
				if (hit < 0) begin
					r.status = slid_pkg::ST_NOT_FOUND;
				end else begin
					for (pos = hit; pos + 1 < list_len; pos++)
						list_vals[pos] = list_vals[pos+1];
					list_len--;
				end
			end
			slid_pkg::KIND_READ: begin
				if (int'(c.index) < list_len)
					r.read_value = list_vals[c.index];
				else
					r.status = slid_pkg::ST_RANGE;
			end
			default: begin
				list_len = 0;
			end
		endcase
		r.count = 7'(list_len);
		return r;
	endfunction

	function automatic logic signed [slid_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return slid_pkg::VAL_W'(int'($urandom_range(0, 16)) - 8);
		if (r == 3) begin
			case ($urandom_range(0, 5))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				3: return 32'sh7fff_fffe;
				4: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [slid_pkg::IDX_W-1:0] pick_index();
		return slid_pkg::IDX_W'($urandom);
	endfunction

	task automatic add_cmd(input logic [slid_pkg::KIND_W-1:0] k,
			input logic signed [slid_pkg::VAL_W-1:0] v,
			input logic [slid_pkg::IDX_W-1:0] i, input bit h);
		list_cmd_t c;
		int        j;
		bit        done;
		c.kind  = k;
		c.value = v;
		c.index = i;
		c.hold  = h;
		pending_cmds.push_back(c);
		case (k)
			slid_pkg::KIND_INSERT: begin
				if (gen_held.size() < LIST_DEPTH)
					gen_held.push_back(v);
			end
			slid_pkg::KIND_DELETE: begin
				done = 1'b0;
				for (j = 0; j < gen_held.size() && !done; j++)
					if (gen_held[j] == v) begin
						gen_held.delete(j);
						done = 1'b1;
					end
			end
			slid_pkg::KIND_CLEAR: begin
				gen_held.delete();
			end
			default: ;
		endcase
	endtask

	task automatic add_random_cmd(input bit h);
		int                                r;
		logic signed [slid_pkg::VAL_W-1:0] v;
		logic [slid_pkg::IDX_W-1:0]        i;
		r = $urandom_range(0, 99);
		v = pick_value();
		i = pick_index();
		if (r < 40) begin
			add_cmd(slid_pkg::KIND_INSERT, v, i, h);
		end else if (r < 65) begin
			if (gen_held.size() != 0 && $urandom_range(0, 3) != 0)
				v = gen_held[$urandom_range(0, gen_held.size() - 1)];
			add_cmd(slid_pkg::KIND_DELETE, v, i, h);
		end else if (r < 97) begin
			if (gen_held.size() != 0 && $urandom_range(0, 3) != 0)
				i = slid_pkg::IDX_W'($urandom_range(0, gen_held.size() - 1));
			add_cmd(slid_pkg::KIND_READ, v, i, h);
		end else begin
			add_cmd(slid_pkg::KIND_CLEAR, v, i, h);
		end
	endtask

	task automatic fill_pending();
		int phase_no;
		int sel;
		int n;
		int base;
		bit h;
		// directed opening
		add_cmd(slid_pkg::KIND_READ,   32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_DELETE, 32'sd5,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, 32'sh7fff_ffff, 6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, 32'sh8000_0000, 6'd63, 1'b0);
		add_cmd(slid_pkg::KIND_INSERT, 32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, 32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, -32'sd1,        6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, 32'sh8000_0000, 6'd0,  1'b0);
		for (n = 0; n < 7; n++)
			add_cmd(slid_pkg::KIND_READ, 32'sh7fff_ffff, slid_pkg::IDX_W'(n), 1'b0);
		add_cmd(slid_pkg::KIND_READ,   32'sd0,         6'd63, 1'b0);
		add_cmd(slid_pkg::KIND_DELETE, 32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_DELETE, 32'sd12345,     6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_DELETE, 32'sh8000_0000, 6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_READ,   32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_CLEAR,  32'sh7fff_ffff, 6'd63, 1'b0);
		add_cmd(slid_pkg::KIND_READ,   32'sd0,         6'd0,  1'b0);
		add_cmd(slid_pkg::KIND_INSERT, -32'sd5,        6'd0,  1'b1);
		base = pending_cmds.size();
		phase_no = 0;
		while (pending_cmds.size() - base < RAND_CMDS) begin
			sel = $urandom_range(0, 9);
			h = (phase_no % 6 == 5);
			if (sel < 6) begin
				n = $urandom_range(20, 80);
				repeat (n) begin
					add_random_cmd(h);
					h = 1'b0;
				end
			end else if (sel < 8) begin
				if ($urandom_range(0, 1) != 0)
					add_cmd(slid_pkg::KIND_CLEAR, pick_value(), pick_index(), h);
				else
					add_random_cmd(h);
				n = LIST_DEPTH - gen_held.size() + $urandom_range(1, 4);
				repeat (n)
					add_cmd(slid_pkg::KIND_INSERT, pick_value(), pick_index(), 1'b0);
				add_cmd(slid_pkg::KIND_READ, pick_value(), 6'd63, 1'b0);
				add_cmd(slid_pkg::KIND_READ, pick_value(), 6'd0, 1'b0);
				repeat ($urandom_range(2, 8))
					add_random_cmd(1'b0);
			end else begin
				n = $urandom_range(5, 30);
				repeat (n) begin
					if (gen_held.size() != 0)
						add_cmd(slid_pkg::KIND_DELETE,
							gen_held[$urandom_range(0, gen_held.size() - 1)],
							pick_index(), h);
					else
						add_cmd(slid_pkg::KIND_DELETE, pick_value(), pick_index(), h);
					h = 1'b0;
				end
			end
			phase_no++;
		end
	endtask

	task automatic check_rsp();
		list_rsp_t e;
		if (expected_rsp.size() == 0) begin
			$error("response beat with nothing outstanding: status %0d count %0d read_value %0d",
				rsp_if.status, rsp_if.count, rsp_if.read_value);
			fail_count++;
		end else begin
			e = expected_rsp.pop_front();
			if (rsp_if.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, rsp_if.status);
				fail_count++;
			end
			if (rsp_if.count !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, rsp_if.count);
				fail_count++;
			end
			if (rsp_if.read_value !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, rsp_if.read_value);
				fail_count++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		fill_pending();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_if.valid || expected_rsp.size() != 0);
		repeat (8) @(negedge clk);
		$display("covered %0d commands: %0d insert, %0d delete, %0d read, %0d clear",
			cmd_beats, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("statuses: %0d ok, %0d full, %0d not found, %0d out of range",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (fail_count == 0 && expected_rsp.size() == 0)
			$display("sorted_list_insert_delete: match");
		else
			$display("sorted_list_insert_delete: mismatch");
		$finish;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid  <= 1'b0;
			cmd_if.kind   <= slid_pkg::KIND_INSERT;
			cmd_if.value  <= '0;
			cmd_if.index  <= '0;
			send_gap      <= 0;
			send_mode_cnt <= 0;
			send_gappy    <= 1'b1;
			quiet_tail    <= 1'b0;
		end else begin
			quiet_tail <= (pending_cmds.size() < TAIL_CMDS);
			if (send_mode_cnt == 0) begin
				send_mode_cnt <= $urandom_range(50, 200);
				send_gappy    <= ($urandom_range(0, 2) != 0);
			end else begin
				send_mode_cnt <= send_mode_cnt - 1;
			end
			if (!cmd_if.valid || cmd_if.ready) begin
				if (send_gap != 0) begin
					send_gap     <= send_gap - 1;
					cmd_if.valid <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					cmd_if.valid <= 1'b0;
				end else if (pending_cmds[0].hold &&
						((cmd_if.valid && cmd_if.ready) || cmd_beats != rsp_beats)) begin
					cmd_if.valid <= 1'b0;
				end else if (!quiet_tail && send_gappy && $urandom_range(0, 7) == 0) begin
					send_gap     <= $urandom_range(0, 10);
					cmd_if.valid <= 1'b0;
				end else begin
					head_cmd = pending_cmds.pop_front();
					cmd_if.valid <= 1'b1;
					cmd_if.kind  <= head_cmd.kind;
					cmd_if.value <= head_cmd.value;
					cmd_if.index <= head_cmd.index;
				end
			end
		end
	end

	// response ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rcv_stall    <= 0;
			rcv_mode_cnt <= 0;
			rcv_gappy    <= 1'b1;
		end else begin
			if (rcv_mode_cnt == 0) begin
				rcv_mode_cnt <= $urandom_range(50, 200);
				rcv_gappy    <= ($urandom_range(0, 2) != 0);
			end else begin
				rcv_mode_cnt <= rcv_mode_cnt - 1;
			end
			if (rcv_stall != 0) begin
				rcv_stall    <= rcv_stall - 1;
				rsp_if.ready <= 1'b0;
			end else if (!quiet_tail && rcv_gappy && $urandom_range(0, 5) == 0) begin
				rcv_stall    <= $urandom_range(0, 10);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// monitor: check response beats, then predict accepted command beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_beats   <= 0;
			rsp_beats   <= 0;
			idle_cycles <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				rsp_beats <= rsp_beats + 1;
				check_rsp();
			end
			if (cmd_if.valid && cmd_if.ready) begin
				list_cmd_t c;
				list_rsp_t r;
				c.kind  = cmd_if.kind;
				c.value = cmd_if.value;
				c.index = cmd_if.index;
				c.hold  = 1'b0;
				r = list_step(c);
				kind_seen[c.kind]++;
				status_seen[r.status]++;
				expected_rsp.push_back(r);
				cmd_beats <= cmd_beats + 1;
			end
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", idle_cycles);
				$display("sorted_list_insert_delete: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
